// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define S20_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define S20_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: sv/s20_pkg.sv
package s20_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int DR_W          = $clog2(DOUBLE_ROUNDS + 1);

   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int KEY_W    = 256;
   localparam int NONCE_W  = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int POS_W    = 32;
   localparam int BLK_BYTES = 64;
   localparam int OFF_W    = $clog2(BLK_BYTES);
   localparam int CTR_W    = POS_W - OFF_W;
   localparam int NWORDS   = 16;
   localparam int WIDX_W   = $clog2(NWORDS);

   localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

   localparam logic [4:0] ROT_0 = 5'd7;
   localparam logic [4:0] ROT_1 = 5'd9;
   localparam logic [4:0] ROT_2 = 5'd13;
   localparam logic [4:0] ROT_3 = 5'd18;

   // word held at each slot in column order and in row order, and their inverses
   localparam logic [WIDX_W-1:0] COL_WORD [NWORDS] = '{
      4'd0, 4'd4, 4'd8, 4'd12, 4'd5, 4'd9, 4'd13, 4'd1,
      4'd10, 4'd14, 4'd2, 4'd6, 4'd15, 4'd3, 4'd7, 4'd11};
   localparam logic [WIDX_W-1:0] COL_POS [NWORDS] = '{
      4'd0, 4'd7, 4'd10, 4'd13, 4'd1, 4'd4, 4'd11, 4'd14,
      4'd2, 4'd5, 4'd8, 4'd15, 4'd3, 4'd6, 4'd9, 4'd12};
   localparam logic [WIDX_W-1:0] ROW_WORD [NWORDS] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4,
      4'd10, 4'd11, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14};
   localparam logic [WIDX_W-1:0] ROW_POS [NWORDS] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
      4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3, CSR_NONCE, CSR_START
   } s20_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_GEN, ST_READ, ST_OUT
   } s20_state_type;

   typedef enum logic [1:0] {
      CS_IDLE, CS_ROUND, CS_FEED
   } s20_core_state_type;

   typedef struct packed {
      logic             start;
      logic [CTR_W-1:0] counter;
   } s20_core_ctl_type;

   typedef struct packed {
      logic              done;
      logic              wr_en;
      logic [WIDX_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } s20_core_status_type;

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input logic [4:0] s);
      return (v << s) | (v >> (6'd32 - {1'b0, s}));
   endfunction

   function automatic logic [WORD_W-1:0] s20_init_word(input logic [WIDX_W-1:0] idx,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [NONCE_W-1:0] nonce,
                                                       input logic [WORD_W-1:0] counter);
      logic [WORD_W-1:0] w;
      case (idx)
         4'd0:    w = SIGMA0;
         4'd1:    w = key[0*WORD_W +: WORD_W];
         4'd2:    w = key[1*WORD_W +: WORD_W];
         4'd3:    w = key[2*WORD_W +: WORD_W];
         4'd4:    w = key[3*WORD_W +: WORD_W];
         4'd5:    w = SIGMA1;
         4'd6:    w = nonce[0 +: WORD_W];
         4'd7:    w = nonce[WORD_W +: WORD_W];
         4'd8:    w = counter;
         4'd9:    w = '0;
         4'd10:   w = SIGMA2;
         4'd11:   w = key[4*WORD_W +: WORD_W];
         4'd12:   w = key[5*WORD_W +: WORD_W];
         4'd13:   w = key[6*WORD_W +: WORD_W];
         4'd14:   w = key[7*WORD_W +: WORD_W];
         default: w = SIGMA3;
      endcase
      return w;
   endfunction

endpackage

// File: sv/s20_req_if.sv
interface s20_req_if import s20_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_in;
   logic              message_start;

   modport source (output valid, output data_in, output message_start, input ready);
   modport sink   (input valid, input data_in, input message_start, output ready);
endinterface

// File: sv/s20_rsp_if.sv
interface s20_rsp_if import s20_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

// File: sv/s20_core.sv
`include "assert_macros.svh"

module s20_core import s20_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  s20_core_ctl_type     ctl,
   input  logic [KEY_W-1:0]     key,
   input  logic [NONCE_W-1:0]   nonce,
   output s20_core_status_type  status
);

   s20_core_state_type state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [1:0]         qr_ff, qr_in;
   logic               half_ff, half_in;
   logic [DR_W-1:0]    dr_ff, dr_in;
   logic [WIDX_W-1:0]  feed_ff, feed_in;
   logic [CTR_W-1:0]   counter_ff, counter_in;
   logic [WORD_W-1:0]  m_ff [NWORDS];
   logic [WORD_W-1:0]  m_in [NWORDS];

   logic [WORD_W-1:0]  sum;
   logic [WORD_W-1:0]  rot;
   logic [WORD_W-1:0]  stepped [NWORDS];
   logic [WORD_W-1:0]  grouped [NWORDS];
   logic [WORD_W-1:0]  permuted [NWORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff    <= step_in;
      qr_ff      <= qr_in;
      half_ff    <= half_in;
      dr_ff      <= dr_in;
      feed_ff    <= feed_in;
      counter_ff <= counter_in;
      m_ff       <= m_in;
   end

   // shared add and rotate of slots 0 and 3, xored into slot 1's word, which lands in slot 0
   always_comb begin
      sum = m_ff[0] + m_ff[3];
      case (step_ff)
         2'd0:    rot = rotl32(sum, ROT_0);
         2'd1:    rot = rotl32(sum, ROT_1);
         2'd2:    rot = rotl32(sum, ROT_2);
         default: rot = rotl32(sum, ROT_3);
      endcase

      stepped = m_ff;
      stepped[0] = m_ff[1] ^ rot;
      stepped[1] = m_ff[2];
      stepped[2] = m_ff[3];
      stepped[3] = m_ff[0];

      // next quarter-round's words move into the working slots
      for (int g = 0; g < NWORDS - 4; g++) begin
         grouped[g] = stepped[g + 4];
      end
      for (int g = 0; g < 4; g++) begin
         grouped[NWORDS - 4 + g] = stepped[g];
      end

      for (int p = 0; p < NWORDS; p++) begin
         if (half_ff) begin
            permuted[p] = grouped[ROW_POS[COL_WORD[p]]];
         end else begin
            permuted[p] = grouped[COL_POS[ROW_WORD[p]]];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      qr_in      = qr_ff;
      half_in    = half_ff;
      dr_in      = dr_ff;
      feed_in    = feed_ff;
      counter_in = counter_ff;
      m_in       = m_ff;
      status     = '0;

      case (state_ff)
         CS_IDLE: begin
            if (ctl.start) begin
               counter_in = ctl.counter;
               for (int p = 0; p < NWORDS; p++) begin
                  m_in[p] = s20_init_word(COL_WORD[p], key, nonce,
                                          {{OFF_W{1'b0}}, ctl.counter});
               end
               step_in  = '0;
               qr_in    = '0;
               half_in  = 1'b0;
               dr_in    = '0;
               state_in = CS_ROUND;
            end
         end
         CS_ROUND: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               qr_in = qr_ff + 2'd1;
               if (qr_ff == 2'd3) begin
                  m_in    = permuted;
                  half_in = ~half_ff;
                  if (half_ff) begin
                     if (dr_ff == DR_W'(DOUBLE_ROUNDS - 1)) begin
                        feed_in  = '0;
                        state_in = CS_FEED;
                     end else begin
                        dr_in = dr_ff + DR_W'(1);
                     end
                  end
               end else begin
                  m_in = grouped;
               end
            end else begin
               m_in = stepped;
            end
         end
         CS_FEED: begin
            status.wr_en   = 1'b1;
            status.wr_addr = COL_WORD[feed_ff];
            status.wr_data = m_ff[0] + s20_init_word(COL_WORD[feed_ff], key, nonce,
                                                     {{OFF_W{1'b0}}, counter_ff});
            for (int i = 0; i < NWORDS - 1; i++) begin
               m_in[i] = m_ff[i + 1];
            end
            m_in[NWORDS - 1] = m_ff[0];
            feed_in = feed_ff + WIDX_W'(1);
            if (feed_ff == WIDX_W'(NWORDS - 1)) begin
               status.done = 1'b1;
               state_in    = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   `S20_ASSERT_NXT(a_start_runs, clock, reset, (state_ff == CS_IDLE) && ctl.start, state_ff == CS_ROUND)
   `S20_ASSERT_NXT(a_done_idles, clock, reset, status.done, state_ff == CS_IDLE)
   `S20_ASSERT_IMP(a_write_in_feed, clock, reset, status.wr_en, state_ff == CS_FEED)

endmodule

// File: sv/salsa20_stream_cipher.sv
// Salsa20/20 stream cipher, 256-bit key, one byte in and one byte out per beat.
// A byte whose keystream block is already held passes from idle through a read
// state, where its keystream word is registered, to an output state that loads
// the result register once the response slot is free; no new byte is accepted
// until the state is back at idle. A byte that begins a message, lands on a
// 64-byte boundary or follows a key or nonce write first builds a block: the
// matrix is loaded, 10 double rounds run at one add-rotate-xor step of a
// quarter-round per cycle through a single shared unit, and feed-forward writes
// 16 keystream words, one keystream word per cycle. Configuration writes are
// to be made only while no byte is in flight; a key or nonce write forces a new
// block on the next byte.

`include "assert_macros.svh"

module salsa20_stream_cipher import s20_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   s20_req_if.sink               req_ch,
   s20_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   s20_state_type      state_ff, state_in;
   logic [NONCE_W-1:0] key_ff [4];
   logic [NONCE_W-1:0] nonce_ff;
   logic [POS_W-1:0]   start_index_ff;
   logic [POS_W-1:0]   position_ff;
   logic [POS_W-1:0]   cur_pos_ff;
   logic [BYTE_W-1:0]  data_ff;
   logic               block_valid_ff;
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_data_ff;
   logic [WORD_W-1:0]  ks_rd_ff;
   logic [WORD_W-1:0]  ks_mem [NWORDS];

   logic [POS_W-1:0]    pos_sel;
   logic                need_gen;
   logic                accept;
   logic                rsp_load;
   logic [BYTE_W-1:0]   ks_byte;
   s20_core_ctl_type    core_ctl;
   s20_core_status_type core_st;

   s20_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (core_ctl),
      .key    ({key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .nonce  (nonce_ff),
      .status (core_st)
   );

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign accept          = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;
   assign rsp_load        = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      case (cur_pos_ff[1:0])
         2'd0:    ks_byte = ks_rd_ff[0*BYTE_W +: BYTE_W];
         2'd1:    ks_byte = ks_rd_ff[1*BYTE_W +: BYTE_W];
         2'd2:    ks_byte = ks_rd_ff[2*BYTE_W +: BYTE_W];
         default: ks_byte = ks_rd_ff[3*BYTE_W +: BYTE_W];
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      pos_sel          = req_ch.message_start ? start_index_ff : position_ff;
      need_gen         = req_ch.message_start || !block_valid_ff ||
                         (pos_sel[OFF_W-1:0] == '0);
      core_ctl.start   = 1'b0;
      core_ctl.counter = pos_sel[POS_W-1:OFF_W];

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               core_ctl.start = need_gen;
               state_in       = need_gen ? ST_GEN : ST_READ;
            end
         end
         ST_GEN: begin
            if (core_st.done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // keystream block, one word per entry
   always_ff @(posedge clock) begin
      if (core_st.wr_en) begin
         ks_mem[core_st.wr_addr] <= core_st.wr_data;
      end
      ks_rd_ff <= ks_mem[cur_pos_ff[OFF_W-1:2]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         key_ff         <= '{default: '0};
         nonce_ff       <= '0;
         start_index_ff <= '0;
         position_ff    <= '0;
         block_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            case (csr_index)
               CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: begin
                  key_ff[csr_index[1:0]] <= csr_wdata;
                  block_valid_ff         <= 1'b0;
               end
               CSR_NONCE: begin
                  nonce_ff       <= csr_wdata;
                  block_valid_ff <= 1'b0;
               end
               CSR_START: start_index_ff <= csr_wdata[POS_W-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            position_ff <= pos_sel + POS_W'(1);
         end
         if (core_st.done) begin
            block_valid_ff <= 1'b1;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_pos_ff <= pos_sel;
         data_ff    <= req_ch.data_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= data_ff ^ ks_byte;
      end
   end

   `S20_ASSERT_NXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)
   `S20_ASSERT_NXT(a_done_then_read, clock, reset, core_st.done, state_ff == ST_READ)
   `S20_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)

endmodule
